/* hw/rtl/ttu_pkg.sv */
// package for the triangle tangent unit: widths, constants and sequencer states
package ttu_pkg;
  localparam int unsigned PosW = 32;
  localparam int unsigned TexW = 20;
  localparam int unsigned OutW = 16;
  localparam int unsigned LimW = 16;
  localparam int unsigned AccW = 56;
  localparam logic [LimW-1:0] LimitReset = 16'hFFFF;

  typedef enum logic [3:0] {
    StIdle, StMul, StDet, StTan, StNorm, StSq, StSqrt, StDiv, StOut
  } state_e;
endpackage

/* hw/rtl/triangle_tangent_unit.sv */
// triangle tangent unit top level: vertex grouping and iterative tangent math
// Vertices arrive on the slave stream and are grouped three at a time into
// triangles. The first two corners of a triangle are taken in one cycle each.
// A third corner starts a sequencer around one shared 33x33 signed
// multiplier: the products, the determinant and the tangent magnitudes,
// one-bit normalizing shifts, 3 square steps, 32 restoring square-root
// steps and a division of 48 steps and a store for each of the three
// components, until the result stands in the output register. A zero
// determinant or a zero tangent goes straight to the output state. The
// slave side is not ready while the sequencer runs.
// The output register is separate from the working registers, so vertices
// are taken while a result waits; a finished triangle waits in its last
// state until the output register is free.
module triangle_tangent_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,    // triangle_limit
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v
  input  logic         s_axis_tuser,   // mesh_start
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [47:0]  m_axis_tdata,   // tangent_x, tangent_y, tangent_z
  output logic         m_axis_tuser    // degenerate
);
  localparam int unsigned PW = ttu_pkg::PosW;
  localparam int unsigned TW = ttu_pkg::TexW;
  localparam int unsigned AW = ttu_pkg::AccW;

  ttu_pkg::state_e state_q, state_d;

  logic [15:0] limit_q, done_q;
  logic [1:0]  corner_q;
  logic signed [PW-1:0] hp_q [6];
  logic signed [TW-1:0] ht_q [4];
  logic signed [PW:0]   e1_q [3], e2_q [3];
  logic signed [TW:0]   d1u_q, d1v_q, d2u_q, d2v_q;
  logic signed [63:0]   prod_q [6];   // d2v*e1 xyz, d1v*e2 xyz
  logic signed [63:0]   det_q;
  logic [AW-1:0]        a_q [3];
  logic [2:0]           neg_q;
  logic [3:0]           step_q;
  logic [6:0]           cnt_q;
  logic [63:0]          s_q, rem_q, res_q, bit_q;
  logic [47:0]          num_q;
  logic [32:0]          qt_q;
  logic [47:0]          dr_q;
  logic [47:0]          tw_q;
  logic                 ov_q, ou_q;
  logic [47:0]          od_q;

  // vertex fields
  logic signed [PW-1:0] vx, vy, vz;
  logic signed [TW-1:0] vu, vv;
  assign vx = s_axis_tdata[31:0];
  assign vy = s_axis_tdata[63:32];
  assign vz = s_axis_tdata[95:64];
  assign vu = s_axis_tdata[115:96];
  assign vv = s_axis_tdata[135:116];

  logic accept;
  assign s_axis_tready = (state_q == ttu_pkg::StIdle);
  assign accept = s_axis_tvalid && s_axis_tready;

  // output register can take a new result
  logic out_free;
  assign out_free = !ov_q || m_axis_tready;

  logic [1:0]  cc;
  logic [15:0] dd;
  assign cc = s_axis_tuser ? 2'd0 : corner_q;
  assign dd = s_axis_tuser ? 16'd0 : done_q;

  // shared multiplier operand select
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  always_comb begin
    ma = '0;
    mb = '0;
    case (step_q)
      4'd0: begin ma = 33'(d2v_q); mb = e1_q[0]; end
      4'd1: begin ma = 33'(d2v_q); mb = e1_q[1]; end
      4'd2: begin ma = 33'(d2v_q); mb = e1_q[2]; end
      4'd3: begin ma = 33'(d1v_q); mb = e2_q[0]; end
      4'd4: begin ma = 33'(d1v_q); mb = e2_q[1]; end
      4'd5: begin ma = 33'(d1v_q); mb = e2_q[2]; end
      4'd6: begin ma = 33'(d1u_q); mb = 33'(d2v_q); end
      4'd7: begin ma = 33'(d2u_q); mb = 33'(d1v_q); end
      default: begin
        ma = $signed({3'b0, a_q[step_q[1:0]][29:0]});
        mb = $signed({3'b0, a_q[step_q[1:0]][29:0]});
      end
    endcase
  end
  assign mp = ma * mb;

  // tangent difference and magnitude
  logic signed [63:0] tdiff;
  logic [1:0] ti;
  assign ti = step_q[1:0];
  assign tdiff = prod_q[ti] - prod_q[3 + ti];

  logic [AW-1:0] mx;
  assign mx = a_q[0] | a_q[1] | a_q[2];

  // square-root step result
  logic        sq_take;
  logic [63:0] res_nx;
  assign sq_take = rem_q >= res_q + bit_q;
  assign res_nx = sq_take ? (res_q >> 1) + bit_q : res_q >> 1;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ttu_pkg::StIdle:
        if (accept && cc == 2'd2 && dd < limit_q) state_d = ttu_pkg::StMul;
      ttu_pkg::StMul:  if (step_q == 4'd7) state_d = ttu_pkg::StDet;
      ttu_pkg::StDet:  state_d = ttu_pkg::StTan;
      ttu_pkg::StTan:
        if (step_q == 4'd2) begin
          if (det_q == 0) state_d = ttu_pkg::StOut;
          else state_d = ttu_pkg::StNorm;
        end
      ttu_pkg::StNorm:
        if (mx == '0) state_d = ttu_pkg::StOut;
        else if (mx[AW-1:30] == '0 && mx[29]) state_d = ttu_pkg::StSq;
      ttu_pkg::StSq:   if (step_q == 4'd10) state_d = ttu_pkg::StSqrt;
      ttu_pkg::StSqrt: if (cnt_q == 7'd31) state_d = ttu_pkg::StDiv;
      ttu_pkg::StDiv:  if (step_q == 4'd2 && cnt_q == 7'd48) state_d = ttu_pkg::StOut;
      ttu_pkg::StOut:  if (out_free) state_d = ttu_pkg::StIdle;
      default: state_d = ttu_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ttu_pkg::StIdle;
      limit_q  <= ttu_pkg::LimitReset;
      done_q   <= '0;
      corner_q <= '0;
      ov_q     <= 1'b0;
      step_q   <= '0;
      cnt_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      if (state_q == ttu_pkg::StOut && out_free) ov_q <= 1'b1;
      else if (m_axis_tready) ov_q <= 1'b0;
      if (accept) begin
        if (cc == 2'd2) begin
          corner_q <= '0;
          done_q <= (dd == 16'hFFFF) ? dd : dd + 16'd1;
        end else begin
          corner_q <= cc + 2'd1;
          done_q <= dd;
        end
      end
      unique case (state_q)
        ttu_pkg::StIdle: step_q <= '0;
        ttu_pkg::StMul:  step_q <= (step_q == 4'd7) ? 4'd0 : step_q + 4'd1;
        ttu_pkg::StDet:  step_q <= '0;
        ttu_pkg::StTan:  step_q <= step_q + 4'd1;
        ttu_pkg::StNorm: step_q <= 4'd8;
        ttu_pkg::StSq: begin
          step_q <= (step_q == 4'd10) ? 4'd0 : step_q + 4'd1;
          cnt_q <= '0;
        end
        ttu_pkg::StSqrt: begin
          cnt_q <= (cnt_q == 7'd31) ? 7'd0 : cnt_q + 7'd1;
          step_q <= '0;
        end
        ttu_pkg::StDiv: begin
          if (cnt_q == 7'd48) begin
            cnt_q <= '0;
            step_q <= step_q + 4'd1;
          end else cnt_q <= cnt_q + 7'd1;
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (cc != 2'd2) begin
        hp_q[cc*3]   <= vx;
        hp_q[cc*3+1] <= vy;
        hp_q[cc*3+2] <= vz;
        ht_q[cc*2]   <= vu;
        ht_q[cc*2+1] <= vv;
      end else begin
        e1_q[0] <= 33'(hp_q[3]) - 33'(hp_q[0]);
        e1_q[1] <= 33'(hp_q[4]) - 33'(hp_q[1]);
        e1_q[2] <= 33'(hp_q[5]) - 33'(hp_q[2]);
        e2_q[0] <= 33'(vx) - 33'(hp_q[0]);
        e2_q[1] <= 33'(vy) - 33'(hp_q[1]);
        e2_q[2] <= 33'(vz) - 33'(hp_q[2]);
        d1u_q <= 21'(ht_q[2]) - 21'(ht_q[0]);
        d1v_q <= 21'(ht_q[3]) - 21'(ht_q[1]);
        d2u_q <= 21'(vu) - 21'(ht_q[0]);
        d2v_q <= 21'(vv) - 21'(ht_q[1]);
      end
    end
    case (state_q)
      ttu_pkg::StMul: begin
        if (step_q < 4'd6) prod_q[step_q[2:0]] <= mp[63:0];
        else if (step_q == 4'd6) det_q <= mp[63:0];
        else det_q <= det_q - mp[63:0];
      end
      ttu_pkg::StTan: begin
        neg_q[ti] <= tdiff[63] ^ det_q[63];
        a_q[ti] <= tdiff[63] ? AW'(-tdiff) : AW'(tdiff);
        s_q <= '0;
      end
      ttu_pkg::StNorm: begin
        if (mx[AW-1:30] != '0) begin
          a_q[0] <= a_q[0] >> 1; a_q[1] <= a_q[1] >> 1; a_q[2] <= a_q[2] >> 1;
        end else if (!mx[29]) begin
          a_q[0] <= a_q[0] << 1; a_q[1] <= a_q[1] << 1; a_q[2] <= a_q[2] << 1;
        end
      end
      ttu_pkg::StSq: begin
        s_q <= s_q + mp[63:0];
        rem_q <= s_q + mp[63:0];
        res_q <= '0;
        bit_q <= 64'h1 << 62;
      end
      ttu_pkg::StSqrt: begin
        if (sq_take) rem_q <= rem_q - (res_q + bit_q);
        res_q <= res_nx;
        bit_q <= bit_q >> 2;
        num_q <= 48'(a_q[0][29:0]) * 48'd16384 + 48'(res_nx[31:1]);
        dr_q <= '0;
        qt_q <= '0;
      end
      ttu_pkg::StDiv: begin
        if (cnt_q == 7'd48) begin
          tw_q[ti*16 +: 16] <= neg_q[ti] ? 16'(-qt_q) : 16'(qt_q);
          num_q <= 48'(a_q[ti + 2'd1][29:0]) * 48'd16384 + 48'(res_q[31:1]);
          dr_q <= '0;
          qt_q <= '0;
        end else begin
          if ({dr_q[46:0], num_q[47]} >= 48'(res_q[31:0])) begin
            dr_q <= {dr_q[46:0], num_q[47]} - 48'(res_q[31:0]);
            qt_q <= {qt_q[31:0], 1'b1};
          end else begin
            dr_q <= {dr_q[46:0], num_q[47]};
            qt_q <= {qt_q[31:0], 1'b0};
          end
          num_q <= num_q << 1;
        end
      end
      ttu_pkg::StOut: begin
        if (out_free) begin
          ou_q <= (det_q == 0) || (mx == '0);
          od_q <= ((det_q == 0) || (mx == '0)) ? '0 : tw_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tuser  = ou_q;
endmodule
